>>> rtl/brsrc_pkg.sv
package brsrc_pkg;

  // Defaults for the top-level parameters.
  localparam int PHASES_DEF         = 512;
  localparam int ZERO_CROSSINGS_DEF = 5;
  localparam int INTERP_BITS_DEF    = 8;
  localparam int HISTORY_DEPTH_DEF  = 16;

  // Coefficients are Q1.15 in this format, so the sum drops COEF_BITS-1 bits.
  localparam int COEF_BITS = 16;

  localparam int FRAC_BITS = 17;
  localparam int PHASE_W   = 22;
  localparam int STEP_W    = 21;
  localparam logic [STEP_W-1:0]  STEP_RESET = STEP_W'(131072);
  localparam logic [PHASE_W-1:0] ONE_PHASE  = PHASE_W'(1) << FRAC_BITS;

  localparam int MAX_OUT = 16;
  localparam int NOUT_W  = 4;

  localparam int SAMPLE_W = 16;
  localparam int CIDX_W   = 12;
  localparam int COEF_W   = 16;
  localparam int TAP_W    = COEF_W + 1;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 16;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  // APB register map: register index = paddr[ADDR_W-1:2].
  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-3:0] REG_PHASE_STEP = '0;

endpackage

>>> rtl/bandlimited_sample_rate_converter.sv
// Channel    Dir  Transfer when                 Contents
// s_axis     in   s_axis_tvalid & s_axis_tready tuser: mode; tdata: index, coef, delta, sample
// m_axis     out  m_axis_tvalid & m_axis_tready tdata: out_sample; tlast: last of the input item
// apb        in   psel & penable & pwrite       phase_step at byte address 0
//
// A table load, or a sample that only fills the history or produces no output, is taken in
// the idle state; otherwise the sample yields up to 16 outputs, each running setup, one
// table and one history memory read per tap, two wing turnarounds, a pipeline drain and
// finish, and the input stays blocked until the last one is loaded into the output register.
// Reset is synchronous and clears the history valid bits, phase, fill count and output valid;
// the coefficient memory holds garbage until loaded. A stalled output holds the engine in its
// finish step until the pending result is taken.
module bandlimited_sample_rate_converter
  import brsrc_pkg::*;
#(
  parameter int PHASES         = PHASES_DEF,
  parameter int ZERO_CROSSINGS = ZERO_CROSSINGS_DEF,
  parameter int INTERP_BITS    = INTERP_BITS_DEF,
  parameter int HISTORY_DEPTH  = HISTORY_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [11:0] table_index, [27:12] coef_value, [43:28] coef_delta, [59:44] sample, rest zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] mode
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [15:0] out_sample
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int TABLE_LEN = PHASES * ZERO_CROSSINGS + 1;
  localparam int TA_W      = $clog2(TABLE_LEN);
  localparam int IDX_W     = $clog2(TABLE_LEN + PHASES);
  localparam int CENTER    = ZERO_CROSSINGS + 1;
  localparam int FILL_THR  = (CENTER > 15) ? 15 : CENTER;
  localparam int HD_W      = $clog2(2 * ZERO_CROSSINGS + 3);
  localparam int HP_W      = $clog2(HISTORY_DEPTH);
  localparam int RW        = $clog2(2 * HISTORY_DEPTH + 2 * ZERO_CROSSINGS + 4);
  localparam int POS_W     = FRAC_BITS + 1 + $clog2(PHASES + 1);
  localparam int PROD1_W   = INTERP_BITS + 1 + COEF_W;
  localparam int PROD2_W   = SAMPLE_W + TAP_W;
  localparam int ACC_W     = PROD2_W + $clog2(2 * ZERO_CROSSINGS + 2) + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN_L,
    ST_SCAN_R,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t state;

  // Configuration.
  logic [STEP_W-1:0] phase_step;
  logic              cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready & (paddr[ADDR_W-1:2] == REG_PHASE_STEP);
  assign prdata = (paddr[ADDR_W-1:2] == REG_PHASE_STEP) ? {{(32-STEP_W){1'b0}}, phase_step}
                                                        : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= STEP_RESET;
    end else if (cfg_we) begin
      phase_step <= pwdata[STEP_W-1:0];
    end
  end

  // Input field split.
  logic [CIDX_W-1:0]   in_index;
  logic [COEF_W-1:0]   in_coef;
  logic [COEF_W-1:0]   in_delta;
  logic [SAMPLE_W-1:0] in_sample;
  logic                in_xfer;
  logic                load_we;
  logic                samp_in;

  assign in_index  = s_axis_tdata[11:0];
  assign in_coef   = s_axis_tdata[27:12];
  assign in_delta  = s_axis_tdata[43:28];
  assign in_sample = s_axis_tdata[59:44];

  assign s_axis_tready = (state == ST_IDLE);
  assign in_xfer       = s_axis_tvalid & s_axis_tready;
  assign load_we       = in_xfer & (s_axis_tuser == MODE_LOAD)
                         & (32'(in_index) < 32'(TABLE_LEN));
  assign samp_in       = in_xfer & (s_axis_tuser == MODE_SAMPLE);

  // Tap sequencer registers.
  logic [PHASE_W-1:0]     phase;
  logic [3:0]             fill_count;
  logic [NOUT_W-1:0]      n_out;
  logic [IDX_W-1:0]       idx;
  logic [HD_W-1:0]        hd;
  logic [IDX_W-1:0]       base_r;
  logic [INTERP_BITS-1:0] eta_l;
  logic [INTERP_BITS-1:0] eta_r;
  logic [HP_W-1:0]        wp;
  logic [HP_W-1:0]        wp_next;

  assign wp_next = (32'(wp) == HISTORY_DEPTH - 1) ? '0 : wp + HP_W'(1);

  // Table position of both wings for the current phase fraction.
  logic [FRAC_BITS:0] frac_l;
  logic [FRAC_BITS:0] frac_r;
  logic [POS_W-1:0]   pos_l;
  logic [POS_W-1:0]   pos_r;

  assign frac_l = {1'b0, phase[FRAC_BITS-1:0]};
  assign frac_r = ONE_PHASE[FRAC_BITS:0] - frac_l;
  assign pos_l  = POS_W'(frac_l) * POS_W'(PHASES);
  assign pos_r  = POS_W'(frac_r) * POS_W'(PHASES);

  // Issue stage: one tap per cycle while the table index stays inside the table.
  logic                   iss;
  logic [INTERP_BITS-1:0] iss_eta;
  logic [RW-1:0]          rsum;
  logic [RW-1:0]          rsum2;
  logic                   hd_in;
  logic [HP_W-1:0]        ra;

  assign iss     = ((state == ST_SCAN_L) || (state == ST_SCAN_R))
                   && (32'(idx) < 32'(TABLE_LEN));
  assign iss_eta = (state == ST_SCAN_L) ? eta_l : eta_r;
  assign hd_in   = RW'(hd) < RW'(HISTORY_DEPTH);
  assign rsum    = RW'(wp) + RW'(HISTORY_DEPTH) - RW'(hd);
  assign rsum2   = (rsum >= RW'(HISTORY_DEPTH)) ? rsum - RW'(HISTORY_DEPTH) : rsum;
  assign ra      = hd_in ? rsum2[HP_W-1:0] : '0;

  // Coefficient memory: {coef, delta} per entry.
  logic [2*COEF_W-1:0] tbl_mem [TABLE_LEN];
  logic [2*COEF_W-1:0] tbl_q;

  always_ff @(posedge clk) begin
    if (load_we) begin
      tbl_mem[TA_W'(in_index)] <= {in_coef, in_delta};
    end
    if (iss) begin
      tbl_q <= tbl_mem[idx[TA_W-1:0]];
    end
  end

  // History ring: the newest sample sits at wp.
  logic [SAMPLE_W-1:0]      hist_mem [HISTORY_DEPTH];
  logic [SAMPLE_W-1:0]      hist_q;
  logic [HISTORY_DEPTH-1:0] hist_vld;

  always_ff @(posedge clk) begin
    if (samp_in) begin
      hist_mem[wp_next] <= in_sample;
    end
    if (iss) begin
      hist_q <= hist_mem[ra];
    end
  end

  // Tap pipeline: A = memory read, B = eta * delta, C = sample * tap, then accumulate.
  logic                      a_vld;
  logic [INTERP_BITS-1:0]    a_eta;
  logic                      a_zero;
  logic                      b_vld;
  logic signed [PROD1_W-1:0] b_prod;
  logic signed [COEF_W-1:0]  b_coef;
  logic signed [SAMPLE_W-1:0] b_samp;
  logic                      c_vld;
  logic signed [PROD2_W-1:0] c_prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [PROD1_W-1:0] b_frac;
  logic signed [TAP_W-1:0]   tap;

  assign b_frac = b_prod >>> INTERP_BITS;
  assign tap    = TAP_W'(b_coef) + b_frac[TAP_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
    end else begin
      a_vld <= iss;
      b_vld <= a_vld;
      c_vld <= b_vld;
    end
    a_eta  <= iss_eta;
    a_zero <= !hd_in || !hist_vld[ra];
    b_prod <= $signed({1'b0, a_eta}) * $signed(tbl_q[COEF_W-1:0]);
    b_coef <= $signed(tbl_q[2*COEF_W-1:COEF_W]);
    b_samp <= a_zero ? '0 : $signed(hist_q);
    c_prod <= b_samp * tap;
  end

  // Output scaling and saturation.
  logic signed [ACC_W-1:0]    acc_sh;
  logic signed [SAMPLE_W-1:0] sat_val;

  assign acc_sh = acc >>> (COEF_BITS - 1);

  always_comb begin
    if (acc_sh > ACC_W'(32767)) begin
      sat_val = 16'sd32767;
    end else if (acc_sh < -ACC_W'(32768)) begin
      sat_val = -16'sd32768;
    end else begin
      sat_val = acc_sh[SAMPLE_W-1:0];
    end
  end

  // Phase bookkeeping after each output.
  logic [PHASE_W-1:0] ph_add;
  logic               cont;
  logic               out_free;

  assign ph_add   = phase + PHASE_W'(phase_step);
  assign cont     = (ph_add < ONE_PHASE) && (n_out != NOUT_W'(MAX_OUT - 1));
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      phase         <= '0;
      fill_count    <= '0;
      n_out         <= '0;
      wp            <= HP_W'(HISTORY_DEPTH - 1);
      hist_vld      <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // The finish step loads the output register itself.
      if (m_axis_tvalid && m_axis_tready && (state != ST_FINISH)) begin
        m_axis_tvalid <= 1'b0;
      end
      if (samp_in) begin
        wp                <= wp_next;
        hist_vld[wp_next] <= 1'b1;
      end
      if (c_vld) begin
        acc <= acc + ACC_W'(c_prod);
      end
      case (state)
        ST_IDLE: begin
          if (samp_in) begin
            if (fill_count < 4'(FILL_THR)) begin
              fill_count <= fill_count + 4'd1;
            end else if (phase >= ONE_PHASE) begin
              // No output falls before the next center sample.
              phase <= phase - ONE_PHASE;
            end else begin
              n_out <= '0;
              state <= ST_SETUP;
            end
          end
        end
        ST_SETUP: begin
          idx    <= IDX_W'(pos_l >> FRAC_BITS);
          base_r <= IDX_W'(pos_r >> FRAC_BITS);
          eta_l  <= pos_l[FRAC_BITS-1 -: INTERP_BITS];
          eta_r  <= pos_r[FRAC_BITS-1 -: INTERP_BITS];
          hd     <= HD_W'(CENTER);
          acc    <= '0;
          state  <= ST_SCAN_L;
        end
        ST_SCAN_L: begin
          if (iss) begin
            idx <= idx + IDX_W'(PHASES);
            hd  <= hd + HD_W'(1);
          end else begin
            idx   <= base_r;
            hd    <= HD_W'(CENTER - 1);
            state <= ST_SCAN_R;
          end
        end
        ST_SCAN_R: begin
          if (iss) begin
            idx <= idx + IDX_W'(PHASES);
            hd  <= hd - HD_W'(1);
          end else begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!a_vld && !b_vld && !c_vld) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= sat_val;
            m_axis_tlast  <= !cont;
            if (cont) begin
              phase <= ph_add;
              n_out <= n_out + NOUT_W'(1);
              state <= ST_SETUP;
            end else begin
              // The output cap can stop the loop early; the phase then restarts at zero.
              phase <= (ph_add >= ONE_PHASE) ? ph_add - ONE_PHASE : '0;
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/brsrc_checker.sv
module brsrc_checker
  import brsrc_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [IN_DATA_W-1:0]  s_axis_tdata,
  input logic                  s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tlast,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic [ADDR_W-1:0]     paddr,
  input logic [31:0]           pwdata,
  input logic [31:0]           prdata,
  input logic                  pready
);

  // Reset empties the output register.
  a_reset_out: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // A pending result keeps its value until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  // A table load never starts the filter engine.
  a_load_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_LOAD) |=> s_axis_tready)
    else $error("input blocked after a table load");

  // The step register reads back what was written.
  a_cfg_read: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && (paddr[ADDR_W-1:2] == REG_PHASE_STEP) |=>
      (paddr[ADDR_W-1:2] != REG_PHASE_STEP) ||
      (prdata == {{(32-STEP_W){1'b0}}, $past(pwdata[STEP_W-1:0])}))
    else $error("phase step readback mismatch");

endmodule

bind bandlimited_sample_rate_converter brsrc_checker u_brsrc_checker (.*);
